// File: src/rck_pkg.sv
// rck_pkg: shared types and constants of the raster convolution block
// holds field widths, register indexes and the result metadata struct
// depends on nothing
package rck_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int LANES      = 4;
  localparam int KROWS      = 6;
  localparam int CFG_W      = 64;
  localparam int REG_IDX_W  = 3;
  localparam int WIDTH_REG_W = 11;
  localparam int ROWS_REG_W = 3;
  localparam int ANCHOR_W   = 10;
  localparam int POS_W      = 13;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int ROWSUM_W   = PROD_W + 2;
  localparam int TOTAL_W    = ROWSUM_W + 3;
  localparam int PIX_MAX    = 255;
  localparam int BORDER_GAP = 8;
  localparam int WIN_TAIL   = LANES - 1;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROWS_IN_USE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROW_0 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROW_1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROW_2 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROW_3 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROW_4 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROW_5 = 3'd7;

  typedef struct packed {
    logic                border;
    logic [ANCHOR_W-1:0] anchor_column;
    logic [ANCHOR_W-1:0] anchor_row;
  } result_meta_t;

endpackage

// File: src/rck_line_store.sv
// rck_line_store: one memory word per column holding that column of the earlier rows
// read-modify-write at the pixel's column, with forwarding of the last write
// depends on rck_pkg
module rck_line_store #(
  parameter int MAX_WIDTH = 1024,
  parameter int LINES     = 5
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic [$clog2(MAX_WIDTH)-1:0]           rd_addr,
  input  logic                                   wr_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]           wr_addr,
  input  logic [rck_pkg::PIX_W-1:0]              px,
  output logic [LINES-1:0][rck_pkg::PIX_W-1:0]   line
);
  import rck_pkg::*;

  logic [LINES*PIX_W-1:0]         mem [MAX_WIDTH];
  logic [LINES-1:0][PIX_W-1:0]    rd_data;
  logic [LINES-1:0][PIX_W-1:0]    wdata;
  logic [LINES-1:0][PIX_W-1:0]    wdata_q;
  logic                           fwd;

  // same column read back-to-back: the write lands at the read edge
  assign line = fwd ? wdata_q : rd_data;

  generate
    if (LINES > 1) begin : g_shift
      assign wdata = {line[LINES-2:0], px};
    end else begin : g_single
      assign wdata = px;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= mem[rd_addr];
      if (wr_valid) begin
        mem[wr_addr] <= wdata;
        wdata_q <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (en) begin
      fwd <= wr_valid && (wr_addr == rd_addr);
    end
  end

endmodule

// File: src/rck_mac.sv
// rck_mac: multiply, row sums and clamp over the pixel window
// three register stages, all advancing on en
// depends on rck_pkg
module rck_mac #(
  parameter int MAX_ROWS = 6
) (
  input  logic                                                     clk,
  input  logic                                                     rst,
  input  logic                                                     en,
  input  logic                                                     in_valid,
  input  rck_pkg::result_meta_t                                    in_meta,
  input  logic [MAX_ROWS-1:0][rck_pkg::LANES-1:0][rck_pkg::PIX_W-1:0] window,
  input  logic [rck_pkg::KROWS-1:0][rck_pkg::CFG_W-1:0]            kernel,
  input  logic [rck_pkg::ROWS_REG_W-1:0]                           rows_eff,
  output logic                                                     out_valid,
  output rck_pkg::result_meta_t                                    out_meta,
  output logic [rck_pkg::PIX_W-1:0]                                out_value
);
  import rck_pkg::*;

  logic signed [PROD_W-1:0]   prod_next [MAX_ROWS][LANES];
  logic signed [PROD_W-1:0]   prod      [MAX_ROWS][LANES];
  logic signed [ROWSUM_W-1:0] rsum_next [MAX_ROWS];
  logic signed [ROWSUM_W-1:0] rsum      [MAX_ROWS];
  logic signed [TOTAL_W-1:0]  total;
  logic [PIX_W-1:0]           value_next;
  logic                       s1_valid, s2_valid;
  result_meta_t               s1_meta, s2_meta;

  // window row wr takes kernel row rows_eff-1-wr; rows past rows_eff weigh nothing
  always_comb begin
    logic [ROWS_REG_W-1:0]    k;
    logic signed [COEF_W-1:0] cf;
    for (int wr = 0; wr < MAX_ROWS; wr++) begin
      k = rows_eff - ROWS_REG_W'(wr) - 1'b1;
      for (int i = 0; i < LANES; i++) begin
        cf = kernel[k][COEF_W*i +: COEF_W];
        if (ROWS_REG_W'(wr) < rows_eff) begin
          prod_next[wr][i] = $signed({1'b0, window[wr][i]}) * cf;
        end else begin
          prod_next[wr][i] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int wr = 0; wr < MAX_ROWS; wr++) begin
      rsum_next[wr] = '0;
      for (int i = 0; i < LANES; i++) begin
        rsum_next[wr] = rsum_next[wr] + {{(ROWSUM_W-PROD_W){prod[wr][i][PROD_W-1]}},
                                          prod[wr][i]};
      end
    end
  end

  always_comb begin
    total = '0;
    for (int wr = 0; wr < MAX_ROWS; wr++) begin
      total = total + {{(TOTAL_W-ROWSUM_W){rsum[wr][ROWSUM_W-1]}}, rsum[wr]};
    end
    if (s2_meta.border) begin
      value_next = '0;
    end else if (total > PIX_MAX) begin
      value_next = PIX_W'(PIX_MAX);
    end else if (total < 0) begin
      value_next = '0;
    end else begin
      value_next = total[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod      <= prod_next;
      s1_meta   <= in_meta;
      rsum      <= rsum_next;
      s2_meta   <= s1_meta;
      out_value <= value_next;
      out_meta  <= s2_meta;
    end
  end

endmodule

// File: src/raster_conv_kx4_clamp.sv
// raster_conv_kx4_clamp: top level of the streaming kx4 convolution
// counters, window registers and the output skid; uses rck_line_store and rck_mac
// depends on rck_pkg
//
// Pixels enter in raster order, one per clock while pixel_stall is low. Each
// beat reads and rewrites the line store word of its column (one synchronous
// memory, MAX_WIDTH words of MAX_ROWS-1 pixels); a repeat of the same column
// on the next beat is forwarded. A result passes stage a, stage b, the rck_mac
// stages and the output register; a two-entry output register keeps input
// beats flowing while one result waits. Positions with column below 3 or in
// the first rows_eff-1 rows (rows_in_use clamped to 1..MAX_ROWS) give no result.
// The line store needs no clearing after reset; its words are written before any result depends on them.
module raster_conv_kx4_clamp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_ROWS   = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  logic [rck_pkg::PIX_W-1:0]        pixel_value,
  input  logic                             frame_start,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [rck_pkg::ANCHOR_W-1:0]     anchor_column,
  output logic [rck_pkg::ANCHOR_W-1:0]     anchor_row,
  output logic [rck_pkg::PIX_W-1:0]        filtered_value,
  input  logic                             write_enable,
  input  logic [rck_pkg::REG_IDX_W-1:0]    register_index,
  input  logic [rck_pkg::CFG_W-1:0]        write_data
);
  import rck_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // configuration
  logic [WIDTH_REG_W-1:0]      image_width;
  logic [ROWS_REG_W-1:0]       rows_in_use;
  logic [KROWS-1:0][CFG_W-1:0] kernel;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_REG_W'(1024);
      rows_in_use <= ROWS_REG_W'(3);
      kernel      <= '0;
    end else if (write_enable) begin
      case (register_index)
        REG_IMAGE_WIDTH:  image_width <= write_data[WIDTH_REG_W-1:0];
        REG_ROWS_IN_USE:  rows_in_use <= write_data[ROWS_REG_W-1:0];
        REG_KERNEL_ROW_0: kernel[0] <= write_data;
        REG_KERNEL_ROW_1: kernel[1] <= write_data;
        REG_KERNEL_ROW_2: kernel[2] <= write_data;
        REG_KERNEL_ROW_3: kernel[3] <= write_data;
        REG_KERNEL_ROW_4: kernel[4] <= write_data;
        REG_KERNEL_ROW_5: kernel[5] <= write_data;
        default: ;
      endcase
    end
  end

  logic [POS_W-1:0]      width_eff;
  logic [ROWS_REG_W-1:0] rows_eff;

  always_comb begin
    if (image_width == '0) begin
      width_eff = POS_W'(1);
    end else if (POS_W'(image_width) > POS_W'(MAX_WIDTH)) begin
      width_eff = POS_W'(MAX_WIDTH);
    end else begin
      width_eff = POS_W'(image_width);
    end
    if (rows_in_use == '0) begin
      rows_eff = ROWS_REG_W'(1);
    end else if (rows_in_use > ROWS_REG_W'(MAX_ROWS)) begin
      rows_eff = ROWS_REG_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_in_use;
    end
  end

  // pipeline control
  logic en, accept;
  logic skid_valid;

  assign en          = !skid_valid;
  assign pixel_stall = skid_valid;
  assign accept      = pixel_valid && en;

  // position of the incoming beat
  logic [CW-1:0]    col_count, col_count_next, cur_col;
  logic [RW-1:0]    row_count, row_count_next, cur_row;
  logic [POS_W-1:0] c13, r13;
  logic             row_end, emit;
  result_meta_t     meta_next;

  always_comb begin
    cur_col = frame_start ? '0 : col_count;
    cur_row = frame_start ? '0 : row_count;
    c13     = POS_W'(cur_col);
    r13     = POS_W'(cur_row);
    row_end = (c13 + 1'b1) >= width_eff;
    if (row_end) begin
      col_count_next = '0;
      row_count_next = (r13 == POS_W'(MAX_HEIGHT - 1)) ? '0 : cur_row + 1'b1;
    end else begin
      col_count_next = cur_col + 1'b1;
      row_count_next = cur_row;
    end
    emit = (c13 >= POS_W'(WIN_TAIL)) && ((r13 + 1'b1) >= POS_W'(rows_eff));
    meta_next.border        = (c13 + POS_W'(BORDER_GAP - WIN_TAIL)) >= width_eff;
    meta_next.anchor_column = ANCHOR_W'(c13 - POS_W'(WIN_TAIL));
    meta_next.anchor_row    = ANCHOR_W'(r13 + 1'b1 - POS_W'(rows_eff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // stage a: line store data arrives
  logic             a_valid, a_emit;
  logic [CW-1:0]    a_col;
  logic [PIX_W-1:0] a_px;
  result_meta_t     a_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_col  <= cur_col;
      a_px   <= pixel_value;
      a_emit <= emit;
      a_meta <= meta_next;
    end
  end

  logic [MAX_ROWS-1:0][PIX_W-1:0] win_in;

  generate
    if (MAX_ROWS > 1) begin : g_lines
      logic [MAX_ROWS-2:0][PIX_W-1:0] line;

      rck_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .LINES     (MAX_ROWS - 1)
      ) u_line_store (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .rd_addr  (cur_col),
        .wr_valid (a_valid),
        .wr_addr  (a_col),
        .px       (a_px),
        .line     (line)
      );

      assign win_in = {line, a_px};
    end else begin : g_no_lines
      assign win_in = a_px;
    end
  endgenerate

  // stage b: window of the latest four columns of each row
  logic [MAX_ROWS-1:0][LANES-1:0][PIX_W-1:0] window;
  logic                                      b_valid;
  result_meta_t                              b_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      window  <= '0;
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid && a_emit;
      if (a_valid) begin
        for (int j = 0; j < MAX_ROWS; j++) begin
          window[j] <= {win_in[j], window[j][LANES-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_meta <= a_meta;
    end
  end

  logic             p_valid;
  result_meta_t     p_meta;
  logic [PIX_W-1:0] p_value;

  rck_mac #(
    .MAX_ROWS (MAX_ROWS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .in_meta   (b_meta),
    .window    (window),
    .kernel    (kernel),
    .rows_eff  (rows_eff),
    .out_valid (p_valid),
    .out_meta  (p_meta),
    .out_value (p_value)
  );

  // output register plus skid entry
  result_meta_t     out_meta, skid_meta;
  logic [PIX_W-1:0] out_value, skid_value;
  logic             take;

  assign take = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= p_valid;
      end
    end else if (p_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_meta  <= skid_meta;
        out_value <= skid_value;
      end else begin
        out_meta  <= p_meta;
        out_value <= p_value;
      end
    end else if (!skid_valid) begin
      skid_meta  <= p_meta;
      skid_value <= p_value;
    end
  end

  assign anchor_column  = out_meta.anchor_column;
  assign anchor_row     = out_meta.anchor_row;
  assign filtered_value = out_value;

endmodule

// File: verif/rck_conv_checker.sv
// rck_conv_checker: watches the pixel, result and register ports of raster_conv_kx4_clamp
// keeps its own copy of the line stores and window, predicts each result beat and compares
// depends on rck_pkg
module rck_conv_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_ROWS   = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  input  logic                          pixel_stall,
  input  logic [rck_pkg::PIX_W-1:0]     pixel_value,
  input  logic                          frame_start,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [rck_pkg::ANCHOR_W-1:0]  anchor_column,
  input  logic [rck_pkg::ANCHOR_W-1:0]  anchor_row,
  input  logic [rck_pkg::PIX_W-1:0]     filtered_value,
  input  logic                          write_enable,
  input  logic [rck_pkg::REG_IDX_W-1:0] register_index,
  input  logic [rck_pkg::CFG_W-1:0]     write_data,
  output int                            failures,
  output int                            outstanding
);
  import rck_pkg::*;

  typedef struct packed {
    logic [ANCHOR_W-1:0] col;
    logic [ANCHOR_W-1:0] row;
    logic [PIX_W-1:0]    value;
  } anchor_out_t;

  logic [WIDTH_REG_W-1:0] cfg_width;
  logic [ROWS_REG_W-1:0]  cfg_rows;
  logic [CFG_W-1:0]       kern [KROWS];

  logic [PIX_W-1:0] line_mem [MAX_ROWS-1][MAX_WIDTH];
  logic [PIX_W-1:0] win [MAX_ROWS][LANES];
  int col_cnt;
  int row_cnt;

  anchor_out_t anchors_due[$];
  int fail_count = 0;
  int due_count = 0;

  assign failures    = fail_count;
  assign outstanding = due_count;

  // one pixel beat: shift the window, rotate the line stores, queue the anchor it completes
  task automatic convolve_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int w, nr, c, r, ac;
    longint acc;
    anchor_out_t due;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    w  = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
    nr = (cfg_rows == 0) ? 1 : (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
    c = col_cnt;
    r = row_cnt;
    if (c >= MAX_WIDTH) c = 0;

    // window row j holds image row r-j
    for (int j = 0; j < MAX_ROWS; j++) begin
      for (int i = 0; i < LANES - 1; i++) win[j][i] = win[j][i+1];
      if (j == 0) win[j][LANES-1] = px;
      else win[j][LANES-1] = line_mem[j-1][c];
    end
    for (int j = MAX_ROWS - 1; j >= 2; j--) line_mem[j-1][c] = line_mem[j-2][c];
    line_mem[0][c] = px;

    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1) % MAX_HEIGHT;
    end else begin
      col_cnt = c + 1;
    end

    if (c < WIN_TAIL || r + 1 < nr) return;

    ac = c - WIN_TAIL;
    due.col   = ac[ANCHOR_W-1:0];
    due.row   = ANCHOR_W'(r + 1 - nr);
    due.value = '0;
    if (ac + BORDER_GAP < w) begin
      acc = 0;
      // kernel row k weights image row anchor+k, which sits in window row nr-1-k
      for (int k = 0; k < nr; k++)
        for (int i = 0; i < LANES; i++)
          acc += longint'(win[nr-1-k][i]) *
                 longint'($signed(kern[k][COEF_W*i +: COEF_W]));
      if (acc > PIX_MAX) due.value = PIX_W'(PIX_MAX);
      else if (acc < 0) due.value = '0;
      else due.value = PIX_W'(acc);
    end
    anchors_due.push_back(due);
  endtask

  always @(posedge clk) begin
    anchor_out_t seen, due;
    if (rst) begin
      cfg_width = 11'd1024;
      cfg_rows  = 3'd3;
      kern      = '{default: '0};
      line_mem  = '{default: '0};
      win       = '{default: '0};
      col_cnt   = 0;
      row_cnt   = 0;
      anchors_due.delete();
    end else begin
      if (write_enable) begin
        case (register_index)
          REG_IMAGE_WIDTH: cfg_width = write_data[WIDTH_REG_W-1:0];
          REG_ROWS_IN_USE: cfg_rows  = write_data[ROWS_REG_W-1:0];
          default:         kern[register_index - REG_KERNEL_ROW_0] = write_data;
        endcase
      end

      if (result_valid && !result_stall) begin
        seen = '{col: anchor_column, row: anchor_row, value: filtered_value};
        if (anchors_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result beat: col %0d row %0d value %0d",
                     seen.col, seen.row, seen.value);
          fail_count++;
        end else begin
          due = anchors_due.pop_front();
          if (seen.col !== due.col || seen.row !== due.row || seen.value !== due.value) begin
            if (fail_count < 10)
              $display({"result mismatch: expected col %0d row %0d value %0d, ",
                        "got col %0d row %0d value %0d"},
                       due.col, due.row, due.value, seen.col, seen.row, seen.value);
            fail_count++;
          end
        end
      end

      if (pixel_valid && !pixel_stall) convolve_pixel(pixel_value, frame_start);
    end
    due_count = anchors_due.size();
  end

endmodule

// File: verif/tb_raster_conv_kx4_clamp.sv
// tb_raster_conv_kx4_clamp: stimulus and verdict for the kx4 raster convolution block
// drives frames of pixels and register settings, random idle on both channels
// depends on rck_pkg, raster_conv_kx4_clamp and rck_conv_checker
module tb_raster_conv_kx4_clamp;
  import rck_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MAX_ROWS      = 6;
  localparam int TOTAL_PIXELS  = 1350;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;

  // pixel value styles
  localparam int PX_ANY  = 0;
  localparam int PX_RAIL = 1;
  localparam int PX_DARK = 2;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  logic [PIX_W-1:0]     pixel_value = '0;
  logic                 frame_start = 1'b0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [ANCHOR_W-1:0]  anchor_column;
  logic [ANCHOR_W-1:0]  anchor_row;
  logic [PIX_W-1:0]     filtered_value;
  logic                 write_enable = 1'b0;
  logic [REG_IDX_W-1:0] register_index = '0;
  logic [CFG_W-1:0]     write_data = '0;

  int failures;
  int outstanding;
  int cycle_count = 0;
  int pixels_sent = 0;
  bit steady_send = 1'b0;
  bit stall_results = 1'b1;
  logic [CFG_W-1:0] kernel_plan [KROWS];

  raster_conv_kx4_clamp #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_ROWS(MAX_ROWS)
  ) u_top (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel_value(pixel_value), .frame_start(frame_start),
    .result_valid(result_valid), .result_stall(result_stall),
    .anchor_column(anchor_column), .anchor_row(anchor_row),
    .filtered_value(filtered_value),
    .write_enable(write_enable), .register_index(register_index), .write_data(write_data)
  );

  rck_conv_checker #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_ROWS(MAX_ROWS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel_value(pixel_value), .frame_start(frame_start),
    .result_valid(result_valid), .result_stall(result_stall),
    .anchor_column(anchor_column), .anchor_row(anchor_row),
    .filtered_value(filtered_value),
    .write_enable(write_enable), .register_index(register_index), .write_data(write_data),
    .failures(failures), .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // result side: after a beat, or now and then while waiting, hold stall for a drawn count
  initial begin
    int unsigned hold;
    forever begin
      @(posedge clk);
      if (!rst && ((result_valid && !result_stall) || $urandom_range(0, 15) == 0)) begin
        hold = stall_results ? $urandom_range(0, 8) : 0;
        if (hold > 0) begin
          @(negedge clk);
          result_stall <= 1'b1;
          repeat (hold) @(negedge clk);
          result_stall <= 1'b0;
        end
      end
    end
  end

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return '0;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(0, 6)) - 16'd3;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_kernel();
    return {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input int style);
    case (style)
      PX_RAIL: return $urandom_range(0, 1) ? 8'(PIX_MAX) : 8'd0;
      PX_DARK: return 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one pixel beat; valid stays high across back-to-back beats
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned gap;
    gap = steady_send ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_value <= px;
    frame_start <= fs;
    do @(posedge clk); while (pixel_stall);
    pixels_sent++;
  endtask

  task automatic send_frame(input int count, input int style, input bit noise, input bit fresh);
    for (int p = 0; p < count; p++)
      send_pixel(pick_pixel(style), (fresh && p == 0) || (noise && $urandom_range(0, 59) == 0));
  endtask

  // stop sending and wait until every predicted result beat has been taken
  task automatic settle();
    @(negedge clk);
    pixel_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= data;
  endtask

  task automatic close_writes();
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  // unused upper data bits carry junk
  task automatic configure(input int width, input int rows);
    logic [CFG_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_IMAGE_WIDTH, {junk[CFG_W-1:WIDTH_REG_W], width[WIDTH_REG_W-1:0]});
    junk = {$urandom, $urandom};
    write_reg(REG_ROWS_IN_USE, {junk[CFG_W-1:ROWS_REG_W], rows[ROWS_REG_W-1:0]});
    for (int k = 0; k < KROWS; k++)
      write_reg(REG_IDX_W'(REG_KERNEL_ROW_0 + k), kernel_plan[k]);
    close_writes();
  endtask

  initial begin
    int width, rows, eff_rows, count;
    logic [CFG_W-1:0] junk;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // rail pixels against extreme coefficients: clamps at both ends, border zeros
    kernel_plan = '{64'hFFFF_0001_8000_7FFF, 64'h0000_0000_0000_0001,
                    pick_kernel(), pick_kernel(), pick_kernel(), pick_kernel()};
    configure(12, 2);
    for (int p = 0; p < 24; p++)
      send_pixel((p < 12) ? ((p % 2) ? 8'd0 : 8'(PIX_MAX)) :
                 (p == 23) ? 8'(PIX_MAX) : 8'((p - 12) * 23), p == 0);
    settle();

    // width 0 acts as 1: run the row counter past its wrap, then widen mid-frame
    foreach (kernel_plan[k]) kernel_plan[k] = pick_kernel();
    steady_send = 1'b1;
    configure(0, 1);
    send_frame(MAX_HEIGHT + 3, PX_ANY, 1'b0, 1'b1);
    settle();
    junk = {$urandom, $urandom};
    write_reg(REG_IMAGE_WIDTH, {junk[CFG_W-1:WIDTH_REG_W], 11'd4});
    close_writes();
    send_frame(8, PX_ANY, 1'b0, 1'b0);
    settle();
    steady_send = 1'b0;

    // widths at and above the line store size, short single-row frames
    foreach (kernel_plan[k]) kernel_plan[k] = pick_kernel();
    configure(2047, 0);
    send_frame(40, PX_ANY, 1'b1, 1'b1);
    send_frame(40, PX_DARK, 1'b0, 1'b1);
    settle();
    configure(1024, 1);
    send_frame(30, PX_RAIL, 1'b0, 1'b1);
    settle();

    // rows above the maximum; shrink width mid-frame with the column already past it
    foreach (kernel_plan[k]) kernel_plan[k] = pick_kernel();
    configure(20, 7);
    send_frame(20 * 6 + 15, PX_DARK, 1'b0, 1'b1);
    settle();
    junk = {$urandom, $urandom};
    write_reg(REG_IMAGE_WIDTH, {junk[CFG_W-1:WIDTH_REG_W], 11'd10});
    close_writes();
    send_frame(31, PX_ANY, 1'b0, 1'b0);
    settle();

    while (pixels_sent < TOTAL_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       width = $urandom_range(1, 8);
        1:       width = $urandom_range(1000, 2047);
        default: width = $urandom_range(9, 24);
      endcase
      rows = (width > 64) ? $urandom_range(0, 1) : $urandom_range(0, 7);
      eff_rows = (rows == 0) ? 1 : (rows > KROWS) ? KROWS : rows;
      foreach (kernel_plan[k]) kernel_plan[k] = pick_kernel();
      configure(width, rows);
      steady_send   = ($urandom_range(0, 3) == 0);
      stall_results = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        if (width > 64) count = $urandom_range(12, 60);
        else count = width * (eff_rows - 1 + $urandom_range(1, 3));
        // a cut-short frame now and then
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
        send_frame(count, $urandom_range(PX_ANY, PX_DARK), $urandom_range(0, 1), 1'b1);
      end
      settle();
    end

    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rck_pkg.sv
src/rck_line_store.sv
src/rck_mac.sv
src/raster_conv_kx4_clamp.sv
verif/rck_conv_checker.sv
verif/tb_raster_conv_kx4_clamp.sv
